/* src/imhtq_pkg.sv */
// ----------------------------------------------------------------------------
// imhtq_pkg
// Shared types, codes and constants for the indexed min-heap timeout queue.
// ----------------------------------------------------------------------------
package imhtq_pkg;

    localparam int HEAP_DEPTH_DEF = 64;
    localparam int ID_COUNT_DEF   = 256;
    localparam int TIME_BITS_DEF  = 32;

    localparam int ID_W    = 8;
    localparam int DL_W    = 32;
    localparam int REM_W   = 43;
    localparam int CNT_W   = 7;
    localparam int MS_PER_S = 1000;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_POP    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_QUERY  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_EMPTY   = 3'd1,
        ST_FULL    = 3'd2,
        ST_NOT_Q   = 3'd3,
        ST_ALREADY = 3'd4
    } status_t;

    typedef struct packed {
        logic [1:0]      op;
        logic [ID_W-1:0] conn_id;
        logic [DL_W-1:0] deadline;
        logic [DL_W-1:0] now;
    } in_word_t;

    typedef struct packed {
        logic [2:0]       status;
        logic [ID_W-1:0]  out_id;
        logic [DL_W-1:0]  out_deadline;
        logic [REM_W-1:0] remaining_ms;
        logic [CNT_W-1:0] queued_count;
    } out_word_t;

    typedef enum logic [3:0] {
        EX_IDLE,
        EX_DECODE,
        EX_RD_SLOT,
        EX_RD_LAST,
        EX_PLACE,
        EX_UP_RD,
        EX_UP_CMP,
        EX_DN_RD,
        EX_DN_CMP,
        EX_QUERY,
        EX_MUL,
        EX_DONE
    } ex_state_t;

endpackage

/* src/indexed_min_heap_timeout_queue.sv */
// ----------------------------------------------------------------------------
// indexed_min_heap_timeout_queue
// Indexed binary min-heap of (id, deadline) timers with insert, pop, remove and query.
// ----------------------------------------------------------------------------
// The time from input word to result word is set by the sift loop in the heap
// engine, which visits a read state and a compare state per heap level.
// Throughput: one word at a time in the engine; a two-word queue lets the input
// side keep accepting while a sift runs.
// Reset: synchronous active-low aresetn empties the heap and marks every id
// not queued at once, with no clearing pass.
module indexed_min_heap_timeout_queue #(
    parameter int HEAP_DEPTH = imhtq_pkg::HEAP_DEPTH_DEF,
    parameter int ID_COUNT   = imhtq_pkg::ID_COUNT_DEF,
    parameter int TIME_BITS  = imhtq_pkg::TIME_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  imhtq_pkg::in_word_t   s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output imhtq_pkg::out_word_t  m_data
);
    logic                q_valid, q_ready;
    imhtq_pkg::in_word_t q_word;

    // Front: hold incoming words
    imhtq_fifo u_fifo (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_valid), .in_ready(s_ready), .in_word(s_data),
        .out_valid(q_valid), .out_ready(q_ready), .out_word(q_word)
    );

    // Back: heap operations
    imhtq_engine #(
        .HEAP_DEPTH(HEAP_DEPTH), .ID_COUNT(ID_COUNT), .TIME_BITS(TIME_BITS)
    ) u_engine (
        .aclk(aclk), .aresetn(aresetn),
        .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd_word(q_word),
        .res_valid(m_valid), .res_ready(m_ready), .res_word(m_data)
    );
endmodule

/* src/imhtq_fifo.sv */
// ----------------------------------------------------------------------------
// imhtq_fifo
// Two-entry queue that decouples the input front from the heap engine.
// ----------------------------------------------------------------------------
module imhtq_fifo (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  imhtq_pkg::in_word_t   in_word,
    output logic                  out_valid,
    input  logic                  out_ready,
    output imhtq_pkg::in_word_t   out_word
);
    imhtq_pkg::in_word_t mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_word  = mem_reg[rp_reg];

    // Write and read pointers, occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (in_valid && in_ready) begin
                mem_reg[wp_reg] <= in_word;
                wp_reg <= ~wp_reg;
            end
            if (out_valid && out_ready)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'((in_valid && in_ready) ? 1 : 0)
                               - 2'((out_valid && out_ready) ? 1 : 0);
        end
    end
endmodule

/* src/imhtq_engine.sv */
// ----------------------------------------------------------------------------
// imhtq_engine
// Heap engine: runs one operation at a time over the heap and id-map memories.
// ----------------------------------------------------------------------------
module imhtq_engine #(
    parameter int HEAP_DEPTH = imhtq_pkg::HEAP_DEPTH_DEF,
    parameter int ID_COUNT   = imhtq_pkg::ID_COUNT_DEF,
    parameter int TIME_BITS  = imhtq_pkg::TIME_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cmd_valid,
    output logic                  cmd_ready,
    input  imhtq_pkg::in_word_t   cmd_word,
    output logic                  res_valid,
    input  logic                  res_ready,
    output imhtq_pkg::out_word_t  res_word
);
    localparam int SW = $clog2(HEAP_DEPTH);
    localparam int CW = $clog2(HEAP_DEPTH + 1);
    localparam int IW = (ID_COUNT > 1) ? $clog2(ID_COUNT) : 1;
    localparam int TW = TIME_BITS;
    localparam int EIW = imhtq_pkg::ID_W;

    // Heap memories (payload) and id map (slot + queued valid bit)
    logic [TW-1:0]  hdl_mem [HEAP_DEPTH];
    logic [EIW-1:0] hid_mem [HEAP_DEPTH];
    logic [SW-1:0]  map_mem [ID_COUNT];
    logic [ID_COUNT-1:0] queued_reg;

    imhtq_pkg::ex_state_t state_reg, state_next;
    imhtq_pkg::in_word_t  cmd_reg;
    logic [CW-1:0]  count_reg;
    logic [CW:0]    pos_reg, pos_next;           // current slot, wide for 2p+2
    logic [TW-1:0]  cur_dl_reg;                  // entry being sifted
    logic [EIW-1:0] cur_id_reg;
    logic [TW-1:0]  a_dl_reg, b_dl_reg;          // parent or children reads
    logic [EIW-1:0] a_id_reg, b_id_reg;
    logic [SW-1:0]  map_rd_reg;
    logic [2:0]     status_reg;
    logic [EIW-1:0] oid_reg;
    logic [TW-1:0]  odl_reg;
    logic [TW-1:0]  diff_reg;
    logic           pos_dl_reg;
    logic [imhtq_pkg::REM_W-1:0] rem_reg;
    logic           res_valid_reg;

    logic [IW-1:0]  cid;
    logic           cid_ok;
    logic [CW:0]    lc, rc, par;
    logic [SW-1:0]  lc_a, rc_a, par_a, pos_a, last_a;

    assign cid    = IW'(cmd_reg.conn_id);
    assign cid_ok = (32'(cmd_reg.conn_id) < ID_COUNT);
    assign lc     = (pos_reg << 1) + (CW+1)'(1);
    assign rc     = (pos_reg << 1) + (CW+1)'(2);
    assign par    = (pos_reg - (CW+1)'(1)) >> 1;
    assign lc_a   = lc[SW-1:0];
    assign rc_a   = rc[SW-1:0];
    assign par_a  = par[SW-1:0];
    assign pos_a  = pos_reg[SW-1:0];
    assign last_a = SW'(count_reg - CW'(1));

    assign cmd_ready = (state_reg == imhtq_pkg::EX_IDLE) && !res_valid_reg;
    assign res_valid = res_valid_reg;
    assign res_word  = '{status: status_reg, out_id: oid_reg,
                         out_deadline: imhtq_pkg::DL_W'(odl_reg),
                         remaining_ms: rem_reg,
                         queued_count: imhtq_pkg::CNT_W'(count_reg)};

    // Next state
    always_comb begin
        state_next = state_reg;
        pos_next   = pos_reg;
        unique case (state_reg)
            imhtq_pkg::EX_IDLE:
                if (cmd_valid && cmd_ready) state_next = imhtq_pkg::EX_DECODE;
            imhtq_pkg::EX_DECODE: begin
                priority case (imhtq_pkg::op_t'(cmd_reg.op))
                    imhtq_pkg::OP_INSERT:
                        if (!cid_ok || queued_reg[cid] || count_reg == CW'(HEAP_DEPTH))
                            state_next = imhtq_pkg::EX_DONE;
                        else begin
                            pos_next   = (CW+1)'(count_reg);
                            state_next = imhtq_pkg::EX_UP_RD;
                        end
                    imhtq_pkg::OP_POP:
                        if (count_reg == '0) state_next = imhtq_pkg::EX_DONE;
                        else begin
                            pos_next   = '0;
                            state_next = imhtq_pkg::EX_RD_SLOT;
                        end
                    imhtq_pkg::OP_REMOVE:
                        if (!cid_ok || !queued_reg[cid]) state_next = imhtq_pkg::EX_DONE;
                        else state_next = imhtq_pkg::EX_RD_SLOT;
                    default:
                        if (count_reg == '0) state_next = imhtq_pkg::EX_DONE;
                        else state_next = imhtq_pkg::EX_QUERY;
                endcase
            end
            imhtq_pkg::EX_RD_SLOT: state_next = imhtq_pkg::EX_RD_LAST;
            imhtq_pkg::EX_RD_LAST: state_next = imhtq_pkg::EX_PLACE;
            imhtq_pkg::EX_PLACE:
                if (pos_reg >= (CW+1)'(count_reg)) state_next = imhtq_pkg::EX_DONE;
                else if (pos_reg != '0) state_next = imhtq_pkg::EX_UP_RD;
                else state_next = imhtq_pkg::EX_DN_RD;
            imhtq_pkg::EX_UP_RD:
                if (pos_reg == '0) state_next = imhtq_pkg::EX_DONE;
                else state_next = imhtq_pkg::EX_UP_CMP;
            imhtq_pkg::EX_UP_CMP:
                if (cur_dl_reg < a_dl_reg) begin
                    pos_next   = par;
                    state_next = imhtq_pkg::EX_UP_RD;
                end else if (cmd_reg.op != imhtq_pkg::OP_INSERT && pos_dl_reg)
                    state_next = imhtq_pkg::EX_DN_RD;
                else
                    state_next = imhtq_pkg::EX_DONE;
            imhtq_pkg::EX_DN_RD:
                if (lc >= (CW+1)'(count_reg)) state_next = imhtq_pkg::EX_DONE;
                else state_next = imhtq_pkg::EX_DN_CMP;
            imhtq_pkg::EX_DN_CMP: begin
                state_next = imhtq_pkg::EX_DONE;
                if (rc < (CW+1)'(count_reg) && b_dl_reg < a_dl_reg && b_dl_reg < cur_dl_reg) begin
                    pos_next   = rc;
                    state_next = imhtq_pkg::EX_DN_RD;
                end else if (a_dl_reg < cur_dl_reg) begin
                    pos_next   = lc;
                    state_next = imhtq_pkg::EX_DN_RD;
                end
            end
            imhtq_pkg::EX_QUERY: state_next = imhtq_pkg::EX_MUL;
            imhtq_pkg::EX_MUL:   state_next = imhtq_pkg::EX_DONE;
            imhtq_pkg::EX_DONE:  state_next = imhtq_pkg::EX_IDLE;
            default:             state_next = imhtq_pkg::EX_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= imhtq_pkg::EX_IDLE;
            count_reg     <= '0;
            queued_reg    <= '0;
            res_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (res_valid_reg && res_ready) res_valid_reg <= 1'b0;
            if (state_reg == imhtq_pkg::EX_DONE) res_valid_reg <= 1'b1;
            if (state_reg == imhtq_pkg::EX_DECODE) begin
                if (cmd_reg.op == imhtq_pkg::OP_INSERT && cid_ok && !queued_reg[cid]
                    && count_reg != CW'(HEAP_DEPTH)) begin
                    queued_reg[cid] <= 1'b1;
                    count_reg       <= count_reg + CW'(1);
                end
            end
            // Drop the taken entry and shrink the heap
            if (state_reg == imhtq_pkg::EX_RD_LAST) begin
                if (32'(a_id_reg) < ID_COUNT) queued_reg[IW'(a_id_reg)] <= 1'b0;
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    // Datapath and memory access
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            imhtq_pkg::EX_IDLE:
                if (cmd_valid && cmd_ready) cmd_reg <= cmd_word;
            imhtq_pkg::EX_DECODE: begin
                status_reg <= imhtq_pkg::ST_OK;
                oid_reg    <= '0;
                odl_reg    <= '0;
                rem_reg    <= '0;
                cur_dl_reg <= TW'(cmd_reg.deadline);
                cur_id_reg <= cmd_reg.conn_id;
                pos_reg    <= pos_next;
                map_rd_reg <= map_mem[cid];
                priority case (imhtq_pkg::op_t'(cmd_reg.op))
                    imhtq_pkg::OP_INSERT:
                        if (!cid_ok) status_reg <= imhtq_pkg::ST_NOT_Q;
                        else if (queued_reg[cid]) status_reg <= imhtq_pkg::ST_ALREADY;
                        else if (count_reg == CW'(HEAP_DEPTH)) status_reg <= imhtq_pkg::ST_FULL;
                    imhtq_pkg::OP_POP:
                        if (count_reg == '0) status_reg <= imhtq_pkg::ST_EMPTY;
                    imhtq_pkg::OP_REMOVE:
                        if (!cid_ok || !queued_reg[cid]) status_reg <= imhtq_pkg::ST_NOT_Q;
                    default:
                        if (count_reg == '0) begin
                            status_reg <= imhtq_pkg::ST_EMPTY;
                            rem_reg    <= '1;
                        end
                endcase
            end
            imhtq_pkg::EX_RD_SLOT: begin
                if (cmd_reg.op == imhtq_pkg::OP_REMOVE) pos_reg <= (CW+1)'(map_rd_reg);
                a_dl_reg <= hdl_mem[(cmd_reg.op == imhtq_pkg::OP_REMOVE) ? map_rd_reg : SW'(0)];
                a_id_reg <= hid_mem[(cmd_reg.op == imhtq_pkg::OP_REMOVE) ? map_rd_reg : SW'(0)];
            end
            imhtq_pkg::EX_RD_LAST: begin
                oid_reg    <= a_id_reg;
                odl_reg    <= a_dl_reg;
                cur_dl_reg <= hdl_mem[last_a];
                cur_id_reg <= hid_mem[last_a];
                b_dl_reg   <= hdl_mem[par_a];
            end
            imhtq_pkg::EX_PLACE: begin
                // Moved entry may need to go down; remember direction
                pos_dl_reg <= 1'b1;
                if (pos_reg < (CW+1)'(count_reg)) begin
                    hdl_mem[pos_a] <= cur_dl_reg;
                    hid_mem[pos_a] <= cur_id_reg;
                    if (32'(cur_id_reg) < ID_COUNT) map_mem[IW'(cur_id_reg)] <= pos_a;
                end
            end
            imhtq_pkg::EX_UP_RD: begin
                hdl_mem[pos_a] <= cur_dl_reg;
                hid_mem[pos_a] <= cur_id_reg;
                if (32'(cur_id_reg) < ID_COUNT) map_mem[IW'(cur_id_reg)] <= pos_a;
                a_dl_reg <= hdl_mem[par_a];
                a_id_reg <= hid_mem[par_a];
            end
            imhtq_pkg::EX_UP_CMP:
                if (cur_dl_reg < a_dl_reg) begin
                    pos_dl_reg     <= 1'b0;
                    hdl_mem[pos_a] <= a_dl_reg;
                    hid_mem[pos_a] <= a_id_reg;
                    if (32'(a_id_reg) < ID_COUNT) map_mem[IW'(a_id_reg)] <= pos_a;
                    pos_reg <= pos_next;
                end
            imhtq_pkg::EX_DN_RD: begin
                hdl_mem[pos_a] <= cur_dl_reg;
                hid_mem[pos_a] <= cur_id_reg;
                if (32'(cur_id_reg) < ID_COUNT) map_mem[IW'(cur_id_reg)] <= pos_a;
                a_dl_reg <= hdl_mem[lc_a];
                a_id_reg <= hid_mem[lc_a];
                b_dl_reg <= hdl_mem[rc_a];
                b_id_reg <= hid_mem[rc_a];
            end
            imhtq_pkg::EX_DN_CMP:
                if (state_next == imhtq_pkg::EX_DN_RD) begin
                    hdl_mem[pos_a] <= (pos_next == rc) ? b_dl_reg : a_dl_reg;
                    hid_mem[pos_a] <= (pos_next == rc) ? b_id_reg : a_id_reg;
                    if (pos_next == rc) begin
                        if (32'(b_id_reg) < ID_COUNT) map_mem[IW'(b_id_reg)] <= pos_a;
                    end else begin
                        if (32'(a_id_reg) < ID_COUNT) map_mem[IW'(a_id_reg)] <= pos_a;
                    end
                    pos_reg <= pos_next;
                end
            imhtq_pkg::EX_QUERY: begin
                oid_reg    <= hid_mem[SW'(0)];
                odl_reg    <= hdl_mem[SW'(0)];
                pos_dl_reg <= hdl_mem[SW'(0)] > TW'(cmd_reg.now);
                diff_reg   <= hdl_mem[SW'(0)] - TW'(cmd_reg.now);
            end
            imhtq_pkg::EX_MUL:
                rem_reg <= pos_dl_reg
                    ? imhtq_pkg::REM_W'(64'(diff_reg) * 64'(imhtq_pkg::MS_PER_S)) : '0;
            default: ;
        endcase
    end
endmodule

/* bench/tb_indexed_min_heap_timeout_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_indexed_min_heap_timeout_queue
// Self-checking bench for the indexed min-heap timeout queue. A behavioral
// heap in the bench predicts every result word; words from the block are
// checked field by field in order. Directed corner cases come first, then
// random insert/pop/remove/query traffic under three idling mixes and one
// long output hold-off that fills the block.
// ----------------------------------------------------------------------------
module tb_indexed_min_heap_timeout_queue;

    localparam int HEAP_DEPTH = imhtq_pkg::HEAP_DEPTH_DEF;
    localparam int ID_COUNT   = imhtq_pkg::ID_COUNT_DEF;
    localparam longint LIMIT_CYCLES = 400000;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    imhtq_pkg::in_word_t  s_data = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    imhtq_pkg::out_word_t m_data;

    // Heap mirror
    logic [imhtq_pkg::DL_W-1:0] hp_dl [HEAP_DEPTH];
    logic [imhtq_pkg::ID_W-1:0] hp_id [HEAP_DEPTH];
    int              slot_map [ID_COUNT];
    bit              queued [ID_COUNT];
    int              n_entries = 0;

    imhtq_pkg::out_word_t expected_q[$];
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    bit        hold_recv = 1'b0;
    int        fails = 0;
    int        words_in = 0;
    int        words_out = 0;
    longint    cycle = 0;

    always #6 aclk = ~aclk;

    indexed_min_heap_timeout_queue i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    function automatic void put_slot(int s, logic [imhtq_pkg::ID_W-1:0] id,
                                     logic [imhtq_pkg::DL_W-1:0] dl);
        hp_id[s] = id;
        hp_dl[s] = dl;
        slot_map[id] = s;
    endfunction

    function automatic void swap_slots(int a, int b);
        logic [imhtq_pkg::ID_W-1:0] ia;
        logic [imhtq_pkg::DL_W-1:0] da;
        ia = hp_id[a];
        da = hp_dl[a];
        put_slot(a, hp_id[b], hp_dl[b]);
        put_slot(b, ia, da);
    endfunction

    function automatic void bubble_up(int s);
        while (s > 0 && hp_dl[s] < hp_dl[(s - 1) / 2]) begin
            swap_slots(s, (s - 1) / 2);
            s = (s - 1) / 2;
        end
    endfunction

    function automatic void bubble_down(int s);
        int best;
        while (s < n_entries) begin
            best = s;
            if (2 * s + 1 < n_entries && hp_dl[2 * s + 1] < hp_dl[best]) best = 2 * s + 1;
            if (2 * s + 2 < n_entries && hp_dl[2 * s + 2] < hp_dl[best]) best = 2 * s + 2;
            if (best == s) break;
            swap_slots(s, best);
            s = best;
        end
    endfunction

    function automatic void extract_slot(int s);
        queued[hp_id[s]] = 1'b0;
        n_entries--;
        if (s < n_entries) begin
            put_slot(s, hp_id[n_entries], hp_dl[n_entries]);
            if (s > 0 && hp_dl[s] < hp_dl[(s - 1) / 2]) bubble_up(s);
            else bubble_down(s);
        end
    endfunction

    // Predict the result word of one operation and advance the mirror
    function automatic imhtq_pkg::out_word_t heap_result(imhtq_pkg::in_word_t w);
        imhtq_pkg::out_word_t r;
        r = '0;
        r.status = imhtq_pkg::ST_OK;
        case (imhtq_pkg::op_t'(w.op))
            imhtq_pkg::OP_INSERT: begin
                if (queued[w.conn_id]) r.status = imhtq_pkg::ST_ALREADY;
                else if (n_entries >= HEAP_DEPTH) r.status = imhtq_pkg::ST_FULL;
                else begin
                    queued[w.conn_id] = 1'b1;
                    put_slot(n_entries, w.conn_id, w.deadline);
                    n_entries++;
                    bubble_up(n_entries - 1);
                end
            end
            imhtq_pkg::OP_POP: begin
                if (n_entries == 0) r.status = imhtq_pkg::ST_EMPTY;
                else begin
                    r.out_id = hp_id[0];
                    r.out_deadline = hp_dl[0];
                    extract_slot(0);
                end
            end
            imhtq_pkg::OP_REMOVE: begin
                if (!queued[w.conn_id]) r.status = imhtq_pkg::ST_NOT_Q;
                else begin
                    r.out_id = w.conn_id;
                    r.out_deadline = hp_dl[slot_map[w.conn_id]];
                    extract_slot(slot_map[w.conn_id]);
                end
            end
            default: begin
                if (n_entries == 0) begin
                    r.status = imhtq_pkg::ST_EMPTY;
                    r.remaining_ms = '1;
                end else begin
                    r.out_id = hp_id[0];
                    r.out_deadline = hp_dl[0];
                    if (hp_dl[0] > w.now)
                        r.remaining_ms = imhtq_pkg::REM_W'((64'(hp_dl[0]) - 64'(w.now))
                                                           * imhtq_pkg::MS_PER_S);
                end
            end
        endcase
        r.queued_count = imhtq_pkg::CNT_W'(n_entries);
        return r;
    endfunction

    // Send one word, with random idle ahead of it; valid stays up between words unless an idle is drawn
    task automatic send_word(imhtq_pkg::op_t op, logic [imhtq_pkg::ID_W-1:0] id,
                             logic [imhtq_pkg::DL_W-1:0] dl,
                             logic [imhtq_pkg::DL_W-1:0] now);
        imhtq_pkg::in_word_t w;
        w.op = op;
        w.conn_id = id;
        w.deadline = dl;
        w.now = now;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_q.push_back(heap_result(w));
        words_in++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    // Receiver ready with random stalls and an optional hold-off
    always @(posedge aclk) begin
        m_ready <= !hold_recv && ($urandom_range(99) >= recv_idle_pct);
    end

    // Check each accepted result word against the oldest expectation
    always @(posedge aclk) begin
        imhtq_pkg::out_word_t e;
        if (aresetn && m_valid && m_ready) begin
            words_out++;
            if (expected_q.size() == 0) begin
                $error("unexpected word %h", m_data);
                fails++;
            end else begin
                e = expected_q.pop_front();
                if (m_data.status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, m_data.status); fails++;
                end
                if (m_data.out_id !== e.out_id) begin
                    $error("out_id exp %0d got %0d", e.out_id, m_data.out_id); fails++;
                end
                if (m_data.out_deadline !== e.out_deadline) begin
                    $error("out_deadline exp %0d got %0d", e.out_deadline,
                           m_data.out_deadline);
                    fails++;
                end
                if (m_data.remaining_ms !== e.remaining_ms) begin
                    $error("remaining_ms exp %0d got %0d", $signed(e.remaining_ms),
                           $signed(m_data.remaining_ms));
                    fails++;
                end
                if (m_data.queued_count !== e.queued_count) begin
                    $error("queued_count exp %0d got %0d", e.queued_count,
                           m_data.queued_count);
                    fails++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle++;
        if (cycle > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycle);
            $display("** indexed_min_heap_timeout_queue: FAILED **");
            $finish;
        end
    end

    task automatic test_corners();
        send_word(imhtq_pkg::OP_POP, 8'd0, '0, '0);
        send_word(imhtq_pkg::OP_QUERY, 8'd0, '0, '0);
        send_word(imhtq_pkg::OP_REMOVE, 8'd255, '0, '0);
        send_word(imhtq_pkg::OP_INSERT, 8'd255, 32'hFFFF_FFFF, '0);
        send_word(imhtq_pkg::OP_INSERT, 8'd255, 32'd5, '0);
        send_word(imhtq_pkg::OP_QUERY, 8'd0, '0, '0);
        send_word(imhtq_pkg::OP_QUERY, 8'd0, '0, 32'hFFFF_FFFF);
        send_word(imhtq_pkg::OP_INSERT, 8'd0, 32'd0, '0);
        send_word(imhtq_pkg::OP_INSERT, 8'd1, 32'd7, '0);
        send_word(imhtq_pkg::OP_INSERT, 8'd2, 32'd7, '0);
        send_word(imhtq_pkg::OP_INSERT, 8'd3, 32'd7, '0);
        send_word(imhtq_pkg::OP_QUERY, 8'd9, 32'd1, 32'd0);
        send_word(imhtq_pkg::OP_POP, 8'd0, '0, '0);
        send_word(imhtq_pkg::OP_QUERY, 8'd0, '0, 32'd7);
        send_word(imhtq_pkg::OP_REMOVE, 8'd2, '0, '0);
        send_word(imhtq_pkg::OP_REMOVE, 8'd2, '0, '0);
        send_word(imhtq_pkg::OP_QUERY, 8'd0, '0, 32'd3);
        drain();
    endtask

    task automatic test_full();
        for (int i = 0; i < HEAP_DEPTH + 2; i++)
            send_word(imhtq_pkg::OP_INSERT, 8'(i + 100), $urandom_range(50), '0);
        send_word(imhtq_pkg::OP_INSERT, 8'd255, 32'd1, '0);
        while (n_entries > 0) send_word(imhtq_pkg::OP_POP, '0, '0, '0);
        send_word(imhtq_pkg::OP_POP, '0, '0, '0);
        drain();
    endtask

    // Random traffic biased toward live ids and small deadline ranges for ties
    task automatic test_random(int count);
        imhtq_pkg::op_t op;
        logic [imhtq_pkg::ID_W-1:0] id;
        logic [imhtq_pkg::DL_W-1:0] dl;
        int k;
        for (int i = 0; i < count; i++) begin
            k = $urandom_range(99);
            op = (k < 45) ? imhtq_pkg::OP_INSERT : (k < 62) ? imhtq_pkg::OP_POP
               : (k < 82) ? imhtq_pkg::OP_REMOVE : imhtq_pkg::OP_QUERY;
            id = (n_entries > 0 && $urandom_range(1)) ? hp_id[$urandom_range(n_entries - 1)]
                                                      : 8'($urandom);
            dl = $urandom_range(1) ? $urandom : $urandom_range(40);
            send_word(op, id, dl, $urandom_range(1) ? $urandom : $urandom_range(40));
        end
        drain();
    endtask

    task automatic test_backpressure();
        hold_recv = 1'b1;
        fork
            begin
                repeat (400) @(posedge aclk);
                hold_recv = 1'b0;
            end
            for (int i = 0; i < 24; i++)
                send_word(i % 3 == 0 ? imhtq_pkg::OP_QUERY : imhtq_pkg::OP_INSERT,
                          8'($urandom), $urandom, $urandom);
        join
        drain();
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_corners();
        test_full();
        send_idle_pct = 38; recv_idle_pct = 55;
        test_random(110);
        send_idle_pct = 55; recv_idle_pct = 38;
        test_random(110);
        send_idle_pct = 0; recv_idle_pct = 0;
        test_backpressure();
        test_random(110);
        $display("covered %0d words in, %0d words out: corners, full heap, ties,",
                 words_in, words_out);
        $display("random mixes under idling and a long output hold-off");
        if (fails == 0 && expected_q.size() == 0)
            $display("** indexed_min_heap_timeout_queue: PASSED **");
        else
            $display("** indexed_min_heap_timeout_queue: FAILED **");
        $finish;
    end
endmodule

/* files.f */
src/imhtq_pkg.sv
src/imhtq_fifo.sv
src/imhtq_engine.sv
src/indexed_min_heap_timeout_queue.sv
bench/tb_indexed_min_heap_timeout_queue.sv
